[sv/pswl_pkg.sv]
package pswl_pkg;

	// Fixed field widths of the request and response beats
	localparam int REQ_TYPE_W  = 2;
	localparam int SESSION_W   = 4;
	localparam int NOW_W       = 32;
	localparam int COUNT_OUT_W = 5;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int MAX_EV_W    = 5;
	localparam int WINDOW_W    = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_EVENTS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW     = 1'd1;

	// Request codes; the unused code behaves as a query
	localparam logic [REQ_TYPE_W-1:0] REQ_SEND  = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd2;

endpackage

[sv/pswl_if.sv]
interface pswl_req_if import pswl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [SESSION_W-1:0]  session;
	logic [NOW_W-1:0]      now_time;

	modport source (output valid, req_type, session, now_time, input ready);
	modport sink   (input valid, req_type, session, now_time, output ready);
endinterface

interface pswl_rsp_if import pswl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   allowed;
	logic [COUNT_OUT_W-1:0] count_in_window;

	modport source (output valid, allowed, count_in_window, input ready);
	modport sink   (input valid, allowed, count_in_window, output ready);
endinterface

[sv/pswl_session_ram.sv]
module pswl_session_ram #(
	parameter int N_SES = 16,
	parameter int HW    = 4,
	parameter int CW    = 5,
	parameter int SW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [SW-1:0] rd_addr,
	output logic [HW-1:0] rd_head,
	output logic [CW-1:0] rd_cnt,
	input  logic          wr_en,
	input  logic          clr_en,
	input  logic [SW-1:0] wr_addr,
	input  logic [HW-1:0] wr_head,
	input  logic [CW-1:0] wr_cnt
);

	logic [HW-1:0]    head_mem [N_SES];
	logic [CW-1:0]    cnt_mem  [N_SES];
	logic [N_SES-1:0] valid_q;
	logic [HW-1:0]    head_rd_q;
	logic [CW-1:0]    cnt_rd_q;
	logic             valid_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			head_mem[wr_addr] <= wr_head;
			cnt_mem[wr_addr]  <= wr_cnt;
		end
		head_rd_q <= head_mem[rd_addr];
		cnt_rd_q  <= cnt_mem[rd_addr];
	end

	// A session never written, or cleared, reads as empty with head zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (clr_en)
				valid_q[wr_addr] <= 1'b0;
			else if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			valid_rd_q <= valid_q[rd_addr];
		end
	end

	assign rd_head = valid_rd_q ? head_rd_q : '0;
	assign rd_cnt  = valid_rd_q ? cnt_rd_q : '0;

endmodule

[sv/per_session_sliding_window_limiter.sv]
// Channel  Modport  Beat fields                       Role
// req      sink     req_type, session, now_time       send / clear / query request
// rsp      source   allowed, count_in_window          one response per request
// cfg      plain    cfg_we, cfg_index, cfg_data       event limit (0), window_ticks (1)
//
// A send or query that prunes pops the stale stamps (at most MAX_EVENTS) before the
// response register is loaded; the prune loop reads the stamp memory once per cycle
// through a single compare unit. A clear, a send with limiting off and a query with a
// zero window skip the prune loop and go straight to ST_DONE.
// req.ready is high only while the sequencer is idle; rsp is held in its own register,
// so a new request is taken while the last response still waits to be taken. A finished
// request then holds in ST_DONE until that register is free.
// Reset clears configuration, the sequencer and the per-session valid bits; the stamp
// memory is left unset.
module per_session_sliding_window_limiter import pswl_pkg::*; #(
	parameter int NUM_SESSIONS = 16,
	parameter int MAX_EVENTS   = 16,
	parameter int TIME_BITS    = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	pswl_req_if.sink               req,
	pswl_rsp_if.source             rsp
);

	localparam int DEPTH = NUM_SESSIONS * MAX_EVENTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
	localparam int HW    = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int CW    = $clog2(MAX_EVENTS + 1);
	localparam int LW    = (CW > MAX_EV_W) ? CW : MAX_EV_W;
	localparam int TW    = TIME_BITS;
	localparam int NW    = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PRUNE,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [MAX_EV_W-1:0]   ev_limit_q;
	logic [WINDOW_W-1:0]   window_q;
	logic [REQ_TYPE_W-1:0] type_q;
	logic [SW-1:0]         ses_q;
	logic [TW-1:0]         now_q;
	logic [TW-1:0]         cutoff_q;
	logic [AW-1:0]         base_q;
	logic [HW-1:0]         head_q;
	logic [CW-1:0]         cnt_q;
	logic                  res_allowed_q;
	logic [LW-1:0]         res_cnt_q;
	logic                  rsp_valid_q;
	logic                  rsp_allowed_q;
	logic [COUNT_OUT_W-1:0] rsp_cnt_q;

	logic [SW-1:0]   smap [16];
	logic [SW-1:0]   in_ses;
	logic [TW-1:0]   in_now;
	logic [TW-1:0]   win_ext;
	logic [SW-1:0]   ses_rd_addr;
	logic [HW-1:0]   ses_head;
	logic [CW-1:0]   ses_cnt;
	logic            ses_we;
	logic            ses_clr;
	logic [LW-1:0]   me_ext;
	logic [LW-1:0]   limit;
	logic            pop;
	logic [HW-1:0]   head_nx;
	logic [HW-1:0]   rd_head;
	logic [AW-1:0]   st_rd_addr;
	logic [HW:0]     slot_sum;
	logic [HW-1:0]   slot;
	logic            refuse;
	logic            st_we;
	logic            slot_free;
	logic            accept;

	logic [TW-1:0]   stamp_mem [DEPTH];
	logic [TW-1:0]   stamp_rd_q;

	// Session index wraps modulo NUM_SESSIONS; a 16-entry constant table
	always_comb begin
		for (int i = 0; i < 16; i++)
			smap[i] = SW'(i % NUM_SESSIONS);
	end

	assign in_ses  = smap[req.session];
	assign in_now  = TW'(req.now_time[NW-1:0]);
	assign win_ext = TW'(window_q);
	assign accept  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	// Read the session entry during idle so it is ready in the load cycle
	assign ses_rd_addr = (state_q == ST_IDLE) ? in_ses : ses_q;

	pswl_session_ram #(
		.N_SES (NUM_SESSIONS),
		.HW    (HW),
		.CW    (CW),
		.SW    (SW)
	) u_ses (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (ses_rd_addr),
		.rd_head (ses_head),
		.rd_cnt  (ses_cnt),
		.wr_en   (ses_we),
		.clr_en  (ses_clr),
		.wr_addr (ses_q),
		.wr_head (head_q),
		.wr_cnt  (refuse ? cnt_q : cnt_q + CW'(1))
	);

	// Effective limit saturates at the ring capacity
	assign me_ext = LW'(ev_limit_q);
	assign limit  = (me_ext > LW'(MAX_EVENTS)) ? LW'(MAX_EVENTS) : me_ext;

	// Prune: pop the oldest stamp while it lies before the cutoff
	assign pop     = (state_q == ST_PRUNE) && (cnt_q != '0) && (stamp_rd_q < cutoff_q);
	assign head_nx = (head_q == HW'(MAX_EVENTS - 1)) ? '0 : head_q + HW'(1);
	assign rd_head = (state_q == ST_LOAD) ? ses_head : (pop ? head_nx : head_q);
	assign st_rd_addr = base_q + AW'(rd_head);

	// Slot for the new stamp: head plus count, wrapped once
	assign slot_sum = (HW + 1)'(head_q) + (HW + 1)'(cnt_q);
	assign slot     = (slot_sum >= (HW + 1)'(MAX_EVENTS)) ?
	                  HW'(slot_sum - (HW + 1)'(MAX_EVENTS)) : HW'(slot_sum);

	assign refuse  = (LW'(cnt_q) >= limit);
	assign ses_we  = (state_q == ST_PRUNE) && !pop && (type_q == REQ_SEND);
	assign st_we   = ses_we && !refuse;
	assign ses_clr = (state_q == ST_LOAD) && (type_q == REQ_CLEAR);

	assign slot_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (st_we)
			stamp_mem[base_q + AW'(slot)] <= now_q;
		stamp_rd_q <= stamp_mem[st_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_limit_q <= '0;
			window_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_EVENTS: ev_limit_q <= cfg_data[MAX_EV_W-1:0];
				CFG_WINDOW:     window_q   <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// Payload of the request in flight; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q   <= req.req_type;
			ses_q    <= in_ses;
			now_q    <= in_now;
			cutoff_q <= (in_now >= win_ext) ? in_now - win_ext : '0;
			base_q   <= AW'(in_ses) * AW'(MAX_EVENTS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rsp_valid_q   <= 1'b0;
			rsp_allowed_q <= 1'b0;
			rsp_cnt_q     <= '0;
			head_q        <= '0;
			cnt_q         <= '0;
			res_allowed_q <= 1'b0;
			res_cnt_q     <= '0;
		end else begin
			// Drop the taken beat unless a new one is loaded in the same cycle
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					head_q        <= ses_head;
					cnt_q         <= ses_cnt;
					res_allowed_q <= 1'b1;
					case (type_q)
						REQ_CLEAR: begin
							res_cnt_q <= '0;
							state_q   <= ST_DONE;
						end
						REQ_SEND: begin
							// Limiting off: allow, report the stored count untouched
							if (ev_limit_q == '0 || window_q == '0) begin
								res_cnt_q <= LW'(ses_cnt);
								state_q   <= ST_DONE;
							end else begin
								state_q <= ST_PRUNE;
							end
						end
						default: begin
							if (window_q == '0) begin
								res_cnt_q <= '0;
								state_q   <= ST_DONE;
							end else begin
								state_q <= ST_PRUNE;
							end
						end
					endcase
				end
				ST_PRUNE: begin
					if (pop) begin
						head_q <= head_nx;
						cnt_q  <= cnt_q - CW'(1);
					end else begin
						if (type_q == REQ_SEND && !refuse) begin
							res_allowed_q <= 1'b1;
							res_cnt_q     <= LW'(cnt_q) + LW'(1);
						end else begin
							res_allowed_q <= (type_q != REQ_SEND);
							res_cnt_q     <= LW'(cnt_q);
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the response register is free
					if (slot_free) begin
						rsp_valid_q   <= 1'b1;
						rsp_allowed_q <= res_allowed_q;
						rsp_cnt_q     <= COUNT_OUT_W'(res_cnt_q);
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.allowed         = rsp_allowed_q;
	assign rsp.count_in_window = rsp_cnt_q;

endmodule

[test/limit_checker.sv]
`timescale 1ns / 1ps
module limit_checker import pswl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	pswl_req_if                    req,
	pswl_rsp_if                    rsp,
	output int                     mismatches,
	output int                     outstanding
);

	localparam int SESSIONS = 16;
	localparam int DEPTH    = 16;

	typedef struct packed {
		logic                   allowed;
		logic [COUNT_OUT_W-1:0] count;
	} verdict_t;

	// Shadow of the per-session timestamp logs and the two limit registers
	logic [NOW_W-1:0]    stamp_log [SESSIONS][DEPTH];
	logic [3:0]          oldest [SESSIONS];
	logic [4:0]          held [SESSIONS];
	logic [MAX_EV_W-1:0] limit_reg;
	logic [WINDOW_W-1:0] window_reg;

	verdict_t due [$];
	verdict_t want;
	int       fails = 0;

	// Pop stamps below the cutoff from the oldest on; return the rest and where the oldest survivor sits
	function automatic logic [4:0] survivors(input logic [3:0] s, input logic [NOW_W-1:0] now,
			output logic [3:0] head);
		logic [NOW_W-1:0] cutoff;
		logic [4:0]       n;
		cutoff = (now >= window_reg) ? now - window_reg : '0;
		head = oldest[s];
		n = held[s];
		while (n != 0 && stamp_log[s][head] < cutoff) begin
			head = head + 4'd1;
			n = n - 5'd1;
		end
		return n;
	endfunction

	function automatic verdict_t predict(input logic [REQ_TYPE_W-1:0] kind,
			input logic [SESSION_W-1:0] s, input logic [NOW_W-1:0] now);
		verdict_t   v;
		logic [3:0] head;
		logic [3:0] slot;
		logic [4:0] n;
		logic [4:0] cap;
		v.allowed = 1'b1;
		case (kind)
			REQ_SEND: begin
				if (limit_reg == 0 || window_reg == 0) begin
					v.count = held[s];
				end else begin
					cap = (limit_reg > DEPTH) ? 5'(DEPTH) : limit_reg;
					n = survivors(s, now, head);
					oldest[s] = head;
					if (n >= cap) begin
						v.allowed = 1'b0;
					end else begin
						slot = head + n[3:0];
						stamp_log[s][slot] = now;
						n = n + 5'd1;
					end
					held[s] = n;
					v.count = n;
				end
			end
			REQ_CLEAR: begin
				oldest[s] = '0;
				held[s] = '0;
				v.count = '0;
			end
			// query, and the spare code which behaves as one
			default: begin
				v.count = (window_reg == 0) ? '0 : survivors(s, now, head);
			end
		endcase
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (held[i]) begin
				held[i] = '0;
				oldest[i] = '0;
			end
			limit_reg = '0;
			window_reg = '0;
			due.delete();
			outstanding <= 0;
			mismatches <= fails;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_EVENTS: limit_reg = cfg_data[MAX_EV_W-1:0];
					CFG_WINDOW:     window_reg = cfg_data[WINDOW_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				due.insert(due.size(), predict(req.req_type, req.session, req.now_time));
			if (rsp.valid && rsp.ready) begin
				if (due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: response beat with nothing pending: allowed=%0d count=%0d",
							$time, rsp.allowed, rsp.count_in_window);
				end else begin
					want = due[0];
					due.delete(0);
					if (rsp.allowed !== want.allowed || rsp.count_in_window !== want.count) begin
						fails++;
						if (fails <= 10)
							$display("%0t: mismatch: expected allowed=%0d count=%0d, got allowed=%0d count=%0d",
								$time, want.allowed, want.count, rsp.allowed, rsp.count_in_window);
					end
				end
			end
			mismatches <= fails;
			outstanding <= due.size();
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import pswl_pkg::*;

	// Spare request code; the limiter treats it as a query
	localparam logic [REQ_TYPE_W-1:0] REQ_SPARE = 2'd3;

	// Longest stretch without any beat or register write before the run is called hung.
	// It stands many times over the slowest correct case: a full prune loop, a sender gap,
	// a receiver stall and a drain.
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 4;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 110;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     mismatches;
	int                     outstanding;

	// Idle rates in percent: gap_pct for the sender, stall_pct for the response side
	int gap_pct = 0;
	int stall_pct = 0;

	// Per-phase limit settings; extremes of both registers are in here
	int limit_plan [PHASES] = '{3, 16, 1, 31, 8, 0, 5, 20, 2, 16};
	int window_plan [PHASES] = '{40, 65535, 1, 1000, 42435, 300, 0, 7, 12000, 23100};

	pswl_req_if req ();
	pswl_rsp_if rsp ();

	per_session_sliding_window_limiter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	limit_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Write both limit registers on consecutive edges; write enable stays high between them
	task automatic set_limits(input logic [MAX_EV_W-1:0] lim, input logic [WINDOW_W-1:0] win);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_EVENTS;
		cfg_data <= CFG_DATA_W'(lim);
		@(posedge clk);
		cfg_index <= CFG_WINDOW;
		cfg_data <= CFG_DATA_W'(win);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop valid and hold until every predicted response beat has been taken.
	// It waits on a clock edge first, so the count reflects a request accepted on the last edge.
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Offer one request beat, maybe after an idle burst, and hold it until accepted.
	// Valid is left high afterwards so that back-to-back beats leave no idle gap.
	task automatic issue(input logic [REQ_TYPE_W-1:0] kind, input logic [SESSION_W-1:0] sess,
			input logic [NOW_W-1:0] now);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.session <= sess;
		req.now_time <= now;
		do @(posedge clk); while (!req.ready);
	endtask

	// Response side: stall in bursts of random length at the current rate, otherwise take beats
	initial begin
		int hold;
		hold = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				rsp.ready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				hold = $urandom_range(0, 5);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Watchdog: count edges with no beat on either channel and no register write
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [NOW_W-1:0]      clock_now;
		logic [NOW_W-1:0]      step_max;
		logic [NOW_W-1:0]      stamp;
		logic [REQ_TYPE_W-1:0] kind;
		logic [SESSION_W-1:0]  sess;
		logic [SESSION_W-1:0]  hot;
		int                    roll;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MAX_EVENTS;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.req_type <= REQ_SEND;
		req.session <= '0;
		req.now_time <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Limits still at their reset values: sends pass unrecorded, queries read zero,
		// and the spare code acts as a query
		issue(REQ_SEND, 4'd0, 32'd0);
		issue(REQ_QUERY, 4'd0, 32'hFFFF_FFFF);
		issue(REQ_SPARE, 4'd15, 32'h8000_0000);

		// Two per window of ten ticks. Early stamps sit below the window, so the cutoff
		// saturates at zero; the third send is refused; a query one tick past the window
		// sees nothing but leaves the log alone, and the next send prunes it
		drain();
		set_limits(5'd2, 16'd10);
		issue(REQ_SEND, 4'd0, 32'd5);
		issue(REQ_SEND, 4'd0, 32'd5);
		issue(REQ_SEND, 4'd0, 32'd6);
		issue(REQ_QUERY, 4'd0, 32'd15);
		issue(REQ_QUERY, 4'd0, 32'd16);
		issue(REQ_SEND, 4'd0, 32'd16);
		issue(REQ_CLEAR, 4'd0, 32'd16);
		issue(REQ_SEND, 4'd15, 32'hFFFF_FFFF);
		issue(REQ_SEND, 4'd15, 32'hFFFF_FFFF);
		issue(REQ_SEND, 4'd15, 32'hFFFF_FFFF);
		issue(REQ_SPARE, 4'd15, 32'hFFFF_FFFF);

		// Limit of zero with the widest window: sends pass and report the stored count
		drain();
		set_limits(5'd0, 16'hFFFF);
		issue(REQ_SEND, 4'd3, 32'd70000);
		issue(REQ_QUERY, 4'd15, 32'd70000);

		// Window of zero with a live limit: sends report the stored count, queries zero
		drain();
		set_limits(5'd4, 16'd0);
		issue(REQ_SEND, 4'd15, 32'd1);
		issue(REQ_QUERY, 4'd15, 32'd1);

		// Random phases: mostly sends to a pair of hot sessions with time advancing by up to
		// about a quarter window per beat, so logs fill, prune and hit the limit; a share
		// of beats go to any session or carry an arbitrary stamp to break the ordering
		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_limits(MAX_EV_W'(limit_plan[p]), WINDOW_W'(window_plan[p]));
			if (p >= PHASES - 2) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 20 : 50);
				stall_pct = (p % 3 == 0) ? 30 : ((p % 3 == 1) ? 0 : 15);
			end
			step_max = NOW_W'(window_plan[p] / 4 + 1);
			hot = SESSION_W'($urandom_range(0, 14));
			if (p == 4)
				clock_now = 32'hFFFF_FF00;
			else if (p % 3 == 0)
				clock_now = $urandom_range(0, 50);
			else
				clock_now = $urandom;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				clock_now = clock_now + $urandom_range(0, step_max);
				roll = $urandom_range(0, 99);
				if (roll < 65)
					kind = REQ_SEND;
				else if (roll < 70)
					kind = REQ_CLEAR;
				else if (roll < 92)
					kind = REQ_QUERY;
				else
					kind = REQ_SPARE;
				if ($urandom_range(0, 4) == 0)
					sess = SESSION_W'($urandom);
				else
					sess = hot + SESSION_W'($urandom_range(0, 1));
				stamp = ($urandom_range(0, 15) == 0) ? NOW_W'($urandom) : clock_now;
				issue(kind, sess, stamp);
			end
		end

		drain();
		repeat (24) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
